>>> sv/meth_pkg.sv
// -----------------------------------------------------------------------------
// meth_pkg
// Shared types and constants for the mesh edge neighbour table: field widths,
// operation codes, controller states and the command/status bundles.
// -----------------------------------------------------------------------------
package meth_pkg;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int POINT_W   = 10;
    localparam int FACE_W    = 12;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // width of the clear generation tag kept with every list length
    localparam int EPOCH_W   = 4;

    // default sizes
    localparam int DEF_NUM_POINTS      = 1024;
    localparam int DEF_FACES_PER_POINT = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LEN_A,
        ST_LEN_B,
        ST_LEN_NB,
        ST_ADD,
        ST_LOAD_B,
        ST_SCAN_A,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic len_sel_b;
        logic latch_na;
        logic latch_nb;
        logic add_commit;
        logic clr_commit;
        logic sweep_en;
        logic load_b;
        logic scan_a;
        logic idx_clr;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sweep_last;
        logic            sweep_req;
        logic            b_done;
        logic            a_done;
        logic            hit;
        logic            out_free;
    } t_status;

endpackage

>>> sv/mesh_edge_neighbour_table.sv
// -----------------------------------------------------------------------------
// mesh_edge_neighbour_table
// Per-point lists of incident faces with add, clear and shared-edge find.
// -----------------------------------------------------------------------------
// sequence: clear and unused codes pass through the a-length lookup to the result;
//   an add also commits its append, and a find looks up both list lengths, loads the
//   b-list and scans the a-list, one face memory read per cycle, ending early on a hit
// transactions: one at a time, next accepted once the result is loaded, or after a due pass
// reset: pass over all NUM_POINTS entries of the length memory, also run
//   after every 16th clear, no input taken meanwhile
module mesh_edge_neighbour_table
    import meth_pkg::*;
#(
    parameter int NUM_POINTS      = DEF_NUM_POINTS,
    parameter int FACES_PER_POINT = DEF_FACES_PER_POINT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // point_a [9:0], point_b [19:10], face_index [31:20]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // op [1:0]
    input  logic [OP_W-1:0]      i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // neighbour_face [11:0], found [12], overflow_error [13], zero [15:14]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_status;

    meth_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    meth_dp #(
        .NUM_POINTS      (NUM_POINTS),
        .FACES_PER_POINT (FACES_PER_POINT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_m_tready (i_m_axis_tready),
        .o_status   (w_status),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

>>> sv/meth_ctrl.sv
// -----------------------------------------------------------------------------
// meth_ctrl
// Sequencer for the neighbour table: clearing pass, operation decode, list
// length lookups, b-list load, a-list scan and result hand-off.
// -----------------------------------------------------------------------------
module meth_ctrl
    import meth_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LEN_A;
            end
            ST_LEN_A: begin
                unique case (i_status.op)
                    OP_ADD:  n_state = ST_ADD;
                    OP_FIND: n_state = ST_LEN_B;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_LEN_B:  n_state = ST_LEN_NB;
            ST_LEN_NB: n_state = ST_LOAD_B;
            ST_ADD:    n_state = ST_DONE;
            ST_LOAD_B: begin
                if (i_status.b_done) n_state = ST_SCAN_A;
            end
            ST_SCAN_A: begin
                if (i_status.hit || i_status.a_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = i_status.sweep_req ? ST_SWEEP : ST_IDLE;
                end
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_SWEEP: o_cmd.sweep_en = 1'b1;
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_LEN_A: begin
                o_cmd.clr_commit = (i_status.op == OP_CLEAR);
            end
            ST_LEN_B: begin
                o_cmd.len_sel_b = 1'b1;
                o_cmd.latch_na  = 1'b1;
            end
            ST_LEN_NB: begin
                o_cmd.latch_nb = 1'b1;
                o_cmd.idx_clr  = 1'b1;
            end
            ST_ADD:    o_cmd.add_commit = 1'b1;
            ST_LOAD_B: begin
                o_cmd.load_b  = 1'b1;
                o_cmd.idx_clr = i_status.b_done;
            end
            ST_SCAN_A: o_cmd.scan_a = 1'b1;
            ST_DONE:   o_cmd.finish = i_status.out_free;
            default: ;
        endcase
    end

endmodule

>>> sv/meth_dp.sv
// -----------------------------------------------------------------------------
// meth_dp
// Datapath of the neighbour table: list length memory with clear tags, face
// memory, b-list registers with parallel compare, overflow flag and the
// output register.
// -----------------------------------------------------------------------------
module meth_dp
    import meth_pkg::*;
#(
    parameter int NUM_POINTS      = DEF_NUM_POINTS,
    parameter int FACES_PER_POINT = DEF_FACES_PER_POINT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [OP_W-1:0]      i_s_tuser,
    input  logic                 i_m_tready,
    output t_status              o_status,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int PT_W       = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int SLOT_W     = $clog2(FACES_PER_POINT);
    localparam int LEN_W      = $clog2(FACES_PER_POINT + 1);
    localparam int LE_W       = EPOCH_W + LEN_W;
    localparam int FA_W       = PT_W + SLOT_W;
    localparam int FACE_DEPTH = NUM_POINTS * (2 ** SLOT_W);
    localparam int PAD_W      = M_TDATA_W - FACE_W - 2;

    // captured item
    logic [OP_W-1:0]    r_op;
    logic [POINT_W-1:0] r_pa;
    logic [POINT_W-1:0] r_pb;
    logic [FACE_W-1:0]  r_face;

    // memories
    logic [LE_W-1:0]   len_mem  [NUM_POINTS];
    logic [FACE_W-1:0] face_mem [FACE_DEPTH];
    logic [LE_W-1:0]   r_len_q;
    logic [FACE_W-1:0] r_face_q;

    // control and working registers
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_sweep_req;
    logic [PT_W-1:0]    r_sweep_cnt;
    logic               r_flag;
    logic [LEN_W-1:0]   r_na;
    logic [LEN_W-1:0]   r_nb;
    logic [LEN_W-1:0]   r_idx;
    logic [LEN_W-1:0]   r_pend_idx;
    logic               r_pend;
    logic [FACE_W-1:0]  r_blist [FACES_PER_POINT];
    logic [FACE_W-1:0]  r_res;
    logic               r_hit;
    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic               w_pa_ok;
    logic               w_pb_ok;
    logic               w_sweep_last;
    logic [PT_W-1:0]    w_len_addr;
    logic [LEN_W-1:0]   w_len_eff;
    logic               w_add_room;
    logic               w_add_ok;
    logic               w_add_full;
    logic [LEN_W-1:0]   w_limit;
    logic               w_issue;
    logic [FA_W-1:0]    w_rd_addr;
    logic [FA_W-1:0]    w_wr_addr;
    logic               w_match;
    logic               w_hit;
    logic               w_out_free;

    // point range checks
    assign w_pa_ok      = (32'(r_pa) < 32'(NUM_POINTS));
    assign w_pb_ok      = (32'(r_pb) < 32'(NUM_POINTS));
    assign w_sweep_last = (r_sweep_cnt == PT_W'(NUM_POINTS - 1));

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_s_tuser;
            r_pa   <= i_s_tdata[POINT_W-1:0];
            r_pb   <= i_s_tdata[2*POINT_W-1:POINT_W];
            r_face <= i_s_tdata[2*POINT_W+FACE_W-1:2*POINT_W];
        end
    end

    // length lookup, stale tag or invalid point reads as empty
    assign w_len_addr = i_cmd.len_sel_b ? PT_W'(r_pb) : PT_W'(r_pa);

    always_comb begin
        w_len_eff = '0;
        if ((i_cmd.latch_nb ? w_pb_ok : w_pa_ok) &&
            (r_len_q[LE_W-1:LEN_W] == r_epoch)) begin
            w_len_eff = r_len_q[LEN_W-1:0];
        end
    end

    assign w_add_room = (w_len_eff < LEN_W'(FACES_PER_POINT));
    assign w_add_ok   = i_cmd.add_commit && w_pa_ok && w_add_room;
    assign w_add_full = i_cmd.add_commit && w_pa_ok && !w_add_room;

    // length memory: sweep writes or add append, one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_en) begin
            len_mem[r_sweep_cnt] <= {r_epoch, LEN_W'(0)};
        end else if (w_add_ok) begin
            len_mem[PT_W'(r_pa)] <= {r_epoch, w_len_eff + LEN_W'(1)};
        end
        r_len_q <= len_mem[w_len_addr];
    end

    // clear generation, sweep request and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch     <= '0;
            r_sweep_req <= 1'b0;
            r_sweep_cnt <= '0;
            r_flag      <= 1'b0;
        end else begin
            if (i_cmd.clr_commit) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
                if (r_epoch == '1) r_sweep_req <= 1'b1;
            end
            if (i_cmd.sweep_en) begin
                if (w_sweep_last) begin
                    r_sweep_cnt <= '0;
                    r_sweep_req <= 1'b0;
                end else begin
                    r_sweep_cnt <= r_sweep_cnt + PT_W'(1);
                end
            end
            if (i_cmd.clr_commit) begin
                r_flag <= 1'b0;
            end else if (w_add_full) begin
                r_flag <= 1'b1;
            end
        end
    end

    // list lengths for find
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_na) r_na <= w_len_eff;
        if (i_cmd.latch_nb) r_nb <= w_len_eff;
    end

    // read issue: one list entry per cycle
    assign w_limit = i_cmd.load_b ? r_nb : r_na;
    assign w_issue = (i_cmd.load_b || i_cmd.scan_a) && (r_idx < w_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.idx_clr) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_issue;
            if (w_issue) r_idx <= r_idx + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_idx;
    end

    // face memory: append on add, registered read for scans
    assign w_rd_addr = {i_cmd.load_b ? PT_W'(r_pb) : PT_W'(r_pa), r_idx[SLOT_W-1:0]};
    assign w_wr_addr = {PT_W'(r_pa), w_len_eff[SLOT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_add_ok) begin
            face_mem[w_wr_addr] <= r_face;
        end
        r_face_q <= face_mem[w_rd_addr];
    end

    // b-list load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_b && r_pend) begin
            r_blist[r_pend_idx[SLOT_W-1:0]] <= r_face_q;
        end
    end

    // compare one a-entry against the whole b-list
    always_comb begin
        w_match = 1'b0;
        for (int j = 0; j < FACES_PER_POINT; j++) begin
            if ((LEN_W'(j) < r_nb) && (r_blist[j] == r_face_q)) w_match = 1'b1;
        end
    end

    assign w_hit = r_pend && w_match && (r_face_q != r_face);

    // find result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_res <= '0;
        end else if (i_cmd.capture) begin
            r_hit <= 1'b0;
            r_res <= '0;
        end else if (i_cmd.scan_a && w_hit) begin
            r_hit <= 1'b1;
            r_res <= r_face_q;
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= {PAD_W'(0), r_flag, r_hit, r_res};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // status to controller
    assign o_status.op         = r_op;
    assign o_status.sweep_last = w_sweep_last;
    assign o_status.sweep_req  = r_sweep_req;
    assign o_status.b_done     = !r_pend && !(r_idx < r_nb);
    assign o_status.a_done     = !r_pend && !(r_idx < r_na);
    assign o_status.hit        = w_hit;
    assign o_status.out_free   = w_out_free;

endmodule

>>> sv/meth_checker.sv
// -----------------------------------------------------------------------------
// meth_checker
// Port-level checks for the neighbour table, bound to the top level.
// -----------------------------------------------------------------------------
module meth_checker
    import meth_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic [1:0] r_outstanding;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // transactions taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_outstanding <= r_outstanding + 2'd1;
        end else if (w_out_acc && !w_in_acc) begin
            r_outstanding <= r_outstanding - 2'd1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // no result without a transaction behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_outstanding != 2'd0)
        else $error("result without pending transaction");

    // at most one in work and one waiting
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding != 2'd3)
        else $error("too many transactions in flight");

    // face and padding are zero whenever nothing was found
    a_face_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[FACE_W] |->
            o_m_axis_tdata[FACE_W-1:0] == '0 &&
            o_m_axis_tdata[M_TDATA_W-1:FACE_W+2] == '0)
        else $error("nonzero face without a find hit");

endmodule

bind mesh_edge_neighbour_table meth_checker u_meth_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
